FILE: hw/rtl/dtt_pkg.sv
package dtt_pkg;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned PT_W    = 3;
  localparam int unsigned PLEN_W  = 16;
  localparam int unsigned ALEN_W  = 8;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned HIDX_W  = 5;

  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_EXEC   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DATA   = 3'd4;

  localparam logic [PT_W-1:0] PT_SW     = 3'd0;
  localparam logic [PT_W-1:0] PT_HW     = 3'd1;
  localparam logic [PT_W-1:0] PT_WRITE  = 3'd2;
  localparam logic [PT_W-1:0] PT_READ   = 3'd3;
  localparam logic [PT_W-1:0] PT_ACCESS = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_LEN = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  typedef struct packed {
    logic [PT_W-1:0]   point_type;
    logic [ADDR_W-1:0] address;
    logic [ALEN_W-1:0] access_len;
    logic              store;
  } req_t;

  typedef struct packed {
    logic same;
    logic exec_hit;
    logic data_hit;
  } match_t;

endpackage

FILE: hw/rtl/debug_trigger_table.sv
// Debug trigger table: breakpoints and watchpoints held in a slot memory.
// Request channel (in_valid_i/in_ready_o) carries insert, remove, clear,
// execution check and data access check requests; every request gives one
// result on the out channel (out_valid_o/out_ready_i).
// The config channel writes debug_enabled; it is always ready. The user must
// write it only while the block is idle; the block itself does not enforce this.
// Requests decided without a table walk (clear, rejected length, unknown type,
// check while disabled, data check with the CPU halted or a zero access
// length) go from acceptance to the finish state and then the result register.
// Others walk the slots through the slot memory and its registered read port,
// one slot per cycle, until a hit or a matching entry ends the walk or every
// slot is read. One request is in work at a time; the next is taken in the
// cycle after the previous result is loaded into the output register, so a
// stalled receiver only blocks once a second result is ready.
// Reset empties the table (used bits clear), clears debug_enabled and
// drops any pending result. Slot contents are not cleared.
module debug_trigger_table #(
  parameter int unsigned NUM_SLOTS       = 32,
  parameter int unsigned MAX_TRIGGER_LEN = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_debug_enabled_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dtt_pkg::REQ_W-1:0]     req_type_i,
  input  logic [dtt_pkg::PT_W-1:0]      point_type_i,
  input  logic [dtt_pkg::ADDR_W-1:0]    address_i,
  input  logic [dtt_pkg::PLEN_W-1:0]    point_len_i,
  input  logic [dtt_pkg::ALEN_W-1:0]    access_len_i,
  input  logic                          store_i,
  input  logic                          cpu_running_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dtt_pkg::STAT_W-1:0]    status_o,
  output logic                          hit_o,
  output logic [dtt_pkg::HIDX_W-1:0]    hit_index_o,
  output logic [dtt_pkg::PT_W-1:0]      hit_type_o
);

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int unsigned LEN_W = $clog2(MAX_TRIGGER_LEN + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [dtt_pkg::REQ_W-1:0]    op_q;
  logic                         act_q;
  dtt_pkg::req_t                req_q;
  logic [LEN_W-1:0]             plen_q;
  logic [CNT_W-1:0]             cnt_q;
  logic                         cmp_vld_q;
  logic [IDX_W-1:0]             cmp_idx_q;
  logic                         found_q;
  logic [IDX_W-1:0]             found_idx_q;
  logic [dtt_pkg::PT_W-1:0]     found_type_q;
  logic                         free_q;
  logic [IDX_W-1:0]             free_idx_q;
  logic [dtt_pkg::STAT_W-1:0]   stat_q;
  logic [NUM_SLOTS-1:0]         used_q;
  logic                         dbg_q;
  logic                         out_vld_q;
  logic [dtt_pkg::STAT_W-1:0]   out_stat_q;
  logic                         out_hit_q;
  logic [IDX_W-1:0]             out_idx_q;
  logic [dtt_pkg::PT_W-1:0]     out_type_q;

  logic                         accept;
  logic                         type_ok;
  logic                         len_ok;
  logic                         start_scan;
  logic                         out_free;
  logic                         rd_en;
  logic                         stop;
  logic                         scan_done;
  logic                         wr_en;
  logic                         fin_hit;
  logic [dtt_pkg::STAT_W-1:0]   fin_stat;
  logic [31:0]                  idx_ext;
  logic [dtt_pkg::PT_W-1:0]     rd_type;
  logic [dtt_pkg::ADDR_W-1:0]   rd_addr;
  logic [LEN_W-1:0]             rd_len;
  dtt_pkg::req_t                req_in;
  dtt_pkg::match_t              match;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_vld_q || out_ready_i;

  assign req_in.point_type = point_type_i;
  assign req_in.address    = address_i;
  assign req_in.access_len = access_len_i;
  assign req_in.store      = store_i;

  assign type_ok = (point_type_i <= dtt_pkg::PT_ACCESS);
  assign len_ok  = (point_len_i != '0) && (32'(point_len_i) <= MAX_TRIGGER_LEN);

  always_comb begin
    start_scan = 1'b0;
    case (req_type_i)
      dtt_pkg::REQ_INSERT,
      dtt_pkg::REQ_REMOVE: start_scan = type_ok && len_ok;
      dtt_pkg::REQ_EXEC:   start_scan = dbg_q;
      dtt_pkg::REQ_DATA:   start_scan = dbg_q && cpu_running_i && (access_len_i != '0);
      default:             start_scan = 1'b0;
    endcase
  end

  assign rd_en = (state_q == ST_SCAN) && (cnt_q < CNT_W'(NUM_SLOTS)) && !stop;

  always_comb begin
    stop = 1'b0;
    if ((state_q == ST_SCAN) && cmp_vld_q) begin
      case (op_q)
        dtt_pkg::REQ_INSERT,
        dtt_pkg::REQ_REMOVE: stop = match.same;
        dtt_pkg::REQ_EXEC:   stop = match.exec_hit;
        dtt_pkg::REQ_DATA:   stop = match.data_hit;
        default:             stop = 1'b0;
      endcase
    end
  end

  assign scan_done = (cnt_q == CNT_W'(NUM_SLOTS)) && !cmp_vld_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = start_scan ? ST_SCAN : ST_FIN;
      ST_SCAN: if (stop || scan_done) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign fin_hit  = found_q && ((op_q == dtt_pkg::REQ_EXEC) || (op_q == dtt_pkg::REQ_DATA));
  assign fin_stat = ((op_q == dtt_pkg::REQ_INSERT) && act_q && !found_q && !free_q) ?
                    dtt_pkg::STAT_FULL : stat_q;
  assign wr_en    = (state_q == ST_FIN) && out_free && (op_q == dtt_pkg::REQ_INSERT) &&
                    act_q && !found_q && free_q;

  dtt_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .LEN_W     (LEN_W),
    .IDX_W     (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_idx_i  (free_idx_q),
    .wr_type_i (req_q.point_type),
    .wr_addr_i (req_q.address),
    .wr_len_i  (plen_q),
    .rd_en_i   (rd_en),
    .rd_idx_i  (cnt_q[IDX_W-1:0]),
    .rd_type_o (rd_type),
    .rd_addr_o (rd_addr),
    .rd_len_o  (rd_len)
  );

  dtt_match #(
    .LEN_W (LEN_W)
  ) u_match (
    .req_i   (req_q),
    .used_i  (used_q[cmp_idx_q]),
    .type_i  (rd_type),
    .addr_i  (rd_addr),
    .len_i   (rd_len),
    .match_o (match)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      dbg_q     <= 1'b0;
      out_vld_q <= 1'b0;
      cmp_vld_q <= 1'b0;
      cnt_q     <= '0;
      act_q     <= 1'b0;
      found_q   <= 1'b0;
      free_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= rd_en;
      if (cfg_valid_i) dbg_q <= cfg_debug_enabled_i;
      if ((state_q == ST_FIN) && out_free) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
      if (rd_en) begin
        cnt_q     <= cnt_q + 1'b1;
        cmp_idx_q <= cnt_q[IDX_W-1:0];
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q    <= req_type_i;
            req_q   <= req_in;
            plen_q  <= point_len_i[LEN_W-1:0];
            cnt_q   <= '0;
            found_q <= 1'b0;
            free_q  <= 1'b0;
            act_q   <= start_scan || (req_type_i == dtt_pkg::REQ_CLEAR);
            stat_q  <= (((req_type_i == dtt_pkg::REQ_INSERT) ||
                         (req_type_i == dtt_pkg::REQ_REMOVE)) && type_ok && !len_ok) ?
                       dtt_pkg::STAT_BAD_LEN : dtt_pkg::STAT_OK;
          end
        end
        ST_SCAN: begin
          if (cmp_vld_q) begin
            if (stop) begin
              found_q      <= 1'b1;
              found_idx_q  <= cmp_idx_q;
              found_type_q <= rd_type;
            end
            if (!used_q[cmp_idx_q] && !free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= cmp_idx_q;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_stat_q <= fin_stat;
            out_hit_q  <= fin_hit;
            out_idx_q  <= fin_hit ? found_idx_q : '0;
            out_type_q <= fin_hit ? found_type_q : '0;
            if (wr_en) used_q[free_idx_q] <= 1'b1;
            if ((op_q == dtt_pkg::REQ_REMOVE) && act_q && found_q) begin
              used_q[found_idx_q] <= 1'b0;
            end
            if ((op_q == dtt_pkg::REQ_CLEAR) && act_q) used_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign idx_ext     = 32'(out_idx_q);
  assign out_valid_o = out_vld_q;
  assign status_o    = out_stat_q;
  assign hit_o       = out_hit_q;
  assign hit_index_o = idx_ext[dtt_pkg::HIDX_W-1:0];
  assign hit_type_o  = out_type_q;

endmodule

FILE: hw/rtl/dtt_slot_mem.sv
module dtt_slot_mem #(
  parameter int unsigned NUM_SLOTS = 32,
  parameter int unsigned LEN_W     = 13,
  parameter int unsigned IDX_W     = 5
) (
  input  logic                            clk_i,
  input  logic                            wr_en_i,
  input  logic [IDX_W-1:0]                wr_idx_i,
  input  logic [dtt_pkg::PT_W-1:0]        wr_type_i,
  input  logic [dtt_pkg::ADDR_W-1:0]      wr_addr_i,
  input  logic [LEN_W-1:0]                wr_len_i,
  input  logic                            rd_en_i,
  input  logic [IDX_W-1:0]                rd_idx_i,
  output logic [dtt_pkg::PT_W-1:0]        rd_type_o,
  output logic [dtt_pkg::ADDR_W-1:0]      rd_addr_o,
  output logic [LEN_W-1:0]                rd_len_o
);

  logic [dtt_pkg::PT_W-1:0]   type_mem [NUM_SLOTS];
  logic [dtt_pkg::ADDR_W-1:0] addr_mem [NUM_SLOTS];
  logic [LEN_W-1:0]           len_mem  [NUM_SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      type_mem[wr_idx_i] <= wr_type_i;
      addr_mem[wr_idx_i] <= wr_addr_i;
      len_mem[wr_idx_i]  <= wr_len_i;
    end
    if (rd_en_i) begin
      rd_type_o <= type_mem[rd_idx_i];
      rd_addr_o <= addr_mem[rd_idx_i];
      rd_len_o  <= len_mem[rd_idx_i];
    end
  end

endmodule

FILE: hw/rtl/dtt_match.sv
module dtt_match #(
  parameter int unsigned LEN_W = 13
) (
  input  dtt_pkg::req_t                   req_i,
  input  logic                            used_i,
  input  logic [dtt_pkg::PT_W-1:0]        type_i,
  input  logic [dtt_pkg::ADDR_W-1:0]      addr_i,
  input  logic [LEN_W-1:0]                len_i,
  output dtt_pkg::match_t                 match_o
);

  logic [dtt_pkg::ADDR_W:0]   req_sum;
  logic [dtt_pkg::ADDR_W:0]   ent_sum;
  logic [dtt_pkg::ADDR_W-1:0] req_end;
  logic [dtt_pkg::ADDR_W-1:0] ent_end;
  logic                       addr_eq;
  logic                       kind_ok;
  logic                       overlap;

  // range ends saturate at the top of the address space
  assign req_sum = {1'b0, req_i.address} + (dtt_pkg::ADDR_W+1)'(req_i.access_len);
  assign ent_sum = {1'b0, addr_i} + (dtt_pkg::ADDR_W+1)'(len_i);
  assign req_end = req_sum[dtt_pkg::ADDR_W] ? '1 : req_sum[dtt_pkg::ADDR_W-1:0];
  assign ent_end = ent_sum[dtt_pkg::ADDR_W] ? '1 : ent_sum[dtt_pkg::ADDR_W-1:0];

  assign addr_eq = (addr_i == req_i.address);
  assign kind_ok = (type_i == dtt_pkg::PT_ACCESS) ||
                   (req_i.store && (type_i == dtt_pkg::PT_WRITE)) ||
                   (!req_i.store && (type_i == dtt_pkg::PT_READ));
  assign overlap = (req_i.address < ent_end) && (addr_i < req_end);

  assign match_o.same     = used_i && (type_i == req_i.point_type) && addr_eq;
  assign match_o.exec_hit = used_i && addr_eq &&
                            ((type_i == dtt_pkg::PT_SW) || (type_i == dtt_pkg::PT_HW));
  assign match_o.data_hit = used_i && kind_ok && overlap;

endmodule

FILE: hw/rtl/debug_trigger_table_chk.sv
module debug_trigger_table_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [dtt_pkg::STAT_W-1:0]    status_o,
  input logic                          hit_o,
  input logic [dtt_pkg::HIDX_W-1:0]    hit_index_o,
  input logic [dtt_pkg::PT_W-1:0]      hit_type_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(hit_o) &&
    $stable(hit_index_o) && $stable(hit_type_o))
    else $error("result changed while stalled");

  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> status_o == dtt_pkg::STAT_OK)
    else $error("hit with nonzero status");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> hit_index_o == '0 && hit_type_o == '0)
    else $error("miss with nonzero index or type");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == dtt_pkg::STAT_OK || status_o == dtt_pkg::STAT_BAD_LEN ||
    status_o == dtt_pkg::STAT_FULL)
    else $error("undefined status");

endmodule

bind debug_trigger_table debug_trigger_table_chk u_chk (.*);

FILE: sim/debug_trigger_table_tb.sv
`timescale 1ns / 100ps

module debug_trigger_table_tb;

  localparam int unsigned SLOTS       = 32;
  localparam int unsigned MAX_LEN     = 4096;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_TAIL  = 48;
  localparam int unsigned PHASES      = 11;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned MAX_PRINTS  = 200;

  localparam logic [dtt_pkg::REQ_W-1:0] REQ_UNKNOWN_LO = 3'd5;
  localparam logic [dtt_pkg::REQ_W-1:0] REQ_UNKNOWN    = 3'd7;
  localparam logic [dtt_pkg::PT_W-1:0]  PT_UNKNOWN_LO  = 3'd5;
  localparam logic [dtt_pkg::PT_W-1:0]  PT_UNKNOWN     = 3'd7;

  localparam logic [dtt_pkg::ADDR_W-1:0] FILL_BASE = 64'h0000_0000_8000_0000;
  localparam logic [dtt_pkg::ADDR_W-1:0] TOP_ADDR  = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [dtt_pkg::REQ_W-1:0]  req_type;
    logic [dtt_pkg::PT_W-1:0]   point_type;
    logic [dtt_pkg::ADDR_W-1:0] address;
    logic [dtt_pkg::PLEN_W-1:0] point_len;
    logic [dtt_pkg::ALEN_W-1:0] access_len;
    logic                       store;
    logic                       cpu_running;
  } trig_req_t;

  typedef struct packed {
    logic [dtt_pkg::STAT_W-1:0] status;
    logic                       hit;
    logic [dtt_pkg::HIDX_W-1:0] hit_index;
    logic [dtt_pkg::PT_W-1:0]   hit_type;
  } trig_result_t;

  typedef struct packed {
    logic         set_cfg;
    logic         cfg_val;
    logic         typed;
    trig_req_t    rq;
    trig_result_t res;
  } stim_row_t;

  localparam trig_result_t RES_UNTYPED = '0;
  localparam trig_result_t RES_OK      =
    {dtt_pkg::STAT_OK, {(1 + dtt_pkg::HIDX_W + dtt_pkg::PT_W){1'b0}}};
  localparam trig_result_t RES_BAD_LEN =
    {dtt_pkg::STAT_BAD_LEN, {(1 + dtt_pkg::HIDX_W + dtt_pkg::PT_W){1'b0}}};

  logic                         clk_i               = 1'b0;
  logic                         rst_ni              = 1'b0;
  logic                         cfg_valid_i         = 1'b0;
  logic                         cfg_ready_o;
  logic                         cfg_debug_enabled_i = 1'b0;
  logic                         in_valid_i          = 1'b0;
  logic                         in_ready_o;
  logic [dtt_pkg::REQ_W-1:0]    req_type_i          = '0;
  logic [dtt_pkg::PT_W-1:0]     point_type_i        = '0;
  logic [dtt_pkg::ADDR_W-1:0]   address_i           = '0;
  logic [dtt_pkg::PLEN_W-1:0]   point_len_i         = '0;
  logic [dtt_pkg::ALEN_W-1:0]   access_len_i        = '0;
  logic                         store_i             = 1'b0;
  logic                         cpu_running_i       = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i         = 1'b0;
  logic [dtt_pkg::STAT_W-1:0]   status_o;
  logic                         hit_o;
  logic [dtt_pkg::HIDX_W-1:0]   hit_index_o;
  logic [dtt_pkg::PT_W-1:0]     hit_type_o;

  // trigger table as the block should hold it
  logic                         trig_used [SLOTS];
  logic [dtt_pkg::PT_W-1:0]     trig_kind [SLOTS];
  logic [dtt_pkg::ADDR_W-1:0]   trig_base [SLOTS];
  logic [dtt_pkg::PLEN_W-1:0]   trig_len  [SLOTS];
  logic                         debugger_on;

  trig_result_t        pending_results [$];
  trig_result_t        want;
  stim_row_t           directed_rows [$];

  int unsigned         cycle_count = 0;
  int unsigned         error_count = 0;
  int                  gap_pct     = 20;
  int                  stall_pct   = 20;
  int                  stall_left  = 0;
  logic                steady      = 1'b0;

  debug_trigger_table #(
    .NUM_SLOTS       (SLOTS),
    .MAX_TRIGGER_LEN (MAX_LEN)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_debug_enabled_i (cfg_debug_enabled_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .req_type_i          (req_type_i),
    .point_type_i        (point_type_i),
    .address_i           (address_i),
    .point_len_i         (point_len_i),
    .access_len_i        (access_len_i),
    .store_i             (store_i),
    .cpu_running_i       (cpu_running_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .hit_o               (hit_o),
    .hit_index_o         (hit_index_o),
    .hit_type_o          (hit_type_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("debug_trigger_table_tb: FAIL");
    $finish;
  end

  task automatic flag_error(input string msg);
    if (error_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    error_count++;
  endtask

  function automatic trig_req_t mk_req(input logic [dtt_pkg::REQ_W-1:0] req,
                                       input logic [dtt_pkg::PT_W-1:0] pt,
                                       input logic [dtt_pkg::ADDR_W-1:0] addr,
                                       input logic [dtt_pkg::PLEN_W-1:0] plen,
                                       input logic [dtt_pkg::ALEN_W-1:0] alen,
                                       input logic wr,
                                       input logic run);
    return {req, pt, addr, plen, alen, wr, run};
  endfunction

  function automatic int find_trigger(input logic [dtt_pkg::PT_W-1:0] kind,
                                      input logic [dtt_pkg::ADDR_W-1:0] addr);
    int idx;
    idx = -1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (trig_used[i] && trig_kind[i] == kind && trig_base[i] == addr) idx = i;
    end
    return idx;
  endfunction

  // end of a byte range, pinned at the top of the address space
  function automatic logic [dtt_pkg::ADDR_W-1:0] range_top(
      input logic [dtt_pkg::ADDR_W-1:0] base,
      input logic [dtt_pkg::ADDR_W-1:0] len);
    logic [dtt_pkg::ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, len};
    return sum[dtt_pkg::ADDR_W] ? {dtt_pkg::ADDR_W{1'b1}} : sum[dtt_pkg::ADDR_W-1:0];
  endfunction

  function automatic logic ranges_overlap(input logic [dtt_pkg::ADDR_W-1:0] a0,
                                          input logic [dtt_pkg::ADDR_W-1:0] alen,
                                          input logic [dtt_pkg::ADDR_W-1:0] b0,
                                          input logic [dtt_pkg::ADDR_W-1:0] blen);
    if (alen == '0 || blen == '0) return 1'b0;
    return (a0 < range_top(b0, blen)) && (b0 < range_top(a0, alen));
  endfunction

  function automatic trig_result_t apply_trigger_request(input trig_req_t r);
    trig_result_t res;
    int           slot;
    logic         placed;
    logic         kind_ok;
    res    = '0;
    slot   = -1;
    placed = 1'b0;
    case (r.req_type)
      dtt_pkg::REQ_INSERT, dtt_pkg::REQ_REMOVE: begin
        if (r.point_type <= dtt_pkg::PT_ACCESS) begin
          if (r.point_len == '0 || r.point_len > MAX_LEN) begin
            res.status = dtt_pkg::STAT_BAD_LEN;
          end else if (r.req_type == dtt_pkg::REQ_REMOVE) begin
            slot = find_trigger(r.point_type, r.address);
            if (slot >= 0) trig_used[slot] = 1'b0;
          end else if (find_trigger(r.point_type, r.address) < 0) begin
            res.status = dtt_pkg::STAT_FULL;
            for (int i = 0; i < SLOTS; i++) begin
              if (!placed && !trig_used[i]) begin
                trig_used[i] = 1'b1;
                trig_kind[i] = r.point_type;
                trig_base[i] = r.address;
                trig_len[i]  = r.point_len;
                placed       = 1'b1;
                res.status   = dtt_pkg::STAT_OK;
              end
            end
          end
        end
      end
      dtt_pkg::REQ_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) trig_used[i] = 1'b0;
      end
      dtt_pkg::REQ_EXEC: begin
        if (debugger_on) begin
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (trig_used[i] &&
                (trig_kind[i] == dtt_pkg::PT_SW || trig_kind[i] == dtt_pkg::PT_HW) &&
                trig_base[i] == r.address) begin
              res.hit       = 1'b1;
              res.hit_index = (dtt_pkg::HIDX_W)'(i);
              res.hit_type  = trig_kind[i];
            end
          end
        end
      end
      dtt_pkg::REQ_DATA: begin
        if (debugger_on && r.cpu_running && r.access_len != '0) begin
          for (int i = SLOTS - 1; i >= 0; i--) begin
            kind_ok = trig_kind[i] == dtt_pkg::PT_ACCESS ||
                      (r.store && trig_kind[i] == dtt_pkg::PT_WRITE) ||
                      (!r.store && trig_kind[i] == dtt_pkg::PT_READ);
            if (trig_used[i] && kind_ok &&
                ranges_overlap(r.address, (dtt_pkg::ADDR_W)'(r.access_len),
                               trig_base[i], (dtt_pkg::ADDR_W)'(trig_len[i]))) begin
              res.hit       = 1'b1;
              res.hit_index = (dtt_pkg::HIDX_W)'(i);
              res.hit_type  = trig_kind[i];
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_request(input trig_req_t r, input logic typed,
                              input trig_result_t typed_res);
    trig_result_t pred;
    in_valid_i    <= 1'b1;
    req_type_i    <= r.req_type;
    point_type_i  <= r.point_type;
    address_i     <= r.address;
    point_len_i   <= r.point_len;
    access_len_i  <= r.access_len;
    store_i       <= r.store;
    cpu_running_i <= r.cpu_running;
    do @(posedge clk_i); while (!in_ready_o);
    pred = apply_trigger_request(r);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic sender_gap();
    if (!steady && $urandom_range(99, 0) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
    end
  endtask

  // only once every outstanding request has its result
  task automatic write_debug_enable(input logic v);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_valid_i         <= 1'b1;
    cfg_debug_enabled_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    debugger_on = v;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        flag_error("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status)
          flag_error($sformatf("status %0d, predicted %0d", status_o, want.status));
        if (hit_o !== want.hit)
          flag_error($sformatf("hit %0b, predicted %0b", hit_o, want.hit));
        if (hit_index_o !== want.hit_index)
          flag_error($sformatf("hit_index %0d, predicted %0d", hit_index_o, want.hit_index));
        if (hit_type_o !== want.hit_type)
          flag_error($sformatf("hit_type %0d, predicted %0d", hit_type_o, want.hit_type));
      end
    end
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (!steady && $urandom_range(99, 0) < stall_pct) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(11, 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    trig_req_t                  r;
    stim_row_t                  row;
    logic [dtt_pkg::ADDR_W-1:0] pool [8];
    logic [dtt_pkg::ADDR_W-1:0] base;
    logic [dtt_pkg::PT_W-1:0]   kinds [5];
    int                         pick;
    int                         lr;
    int                         off;

    kinds = '{dtt_pkg::PT_SW, dtt_pkg::PT_HW, dtt_pkg::PT_WRITE, dtt_pkg::PT_READ,
              dtt_pkg::PT_ACCESS};
    for (int i = 0; i < SLOTS; i++) trig_used[i] = 1'b0;
    debugger_on = 1'b0;

    // set_cfg, cfg_val, typed, request, typed result
    directed_rows.push_back({3'b001, mk_req(dtt_pkg::REQ_EXEC, dtt_pkg::PT_SW, '0, 16'd1,
                             8'd0, 1'b0, 1'b0), RES_OK});
    directed_rows.push_back({3'b001, mk_req(dtt_pkg::REQ_INSERT, dtt_pkg::PT_SW, 64'h1000,
                             16'd0, 8'd0, 1'b0, 1'b1), RES_BAD_LEN});
    directed_rows.push_back({3'b001, mk_req(dtt_pkg::REQ_INSERT, dtt_pkg::PT_HW, 64'h1000,
                             16'd4097, 8'd0, 1'b0, 1'b1), RES_BAD_LEN});
    directed_rows.push_back({3'b001, mk_req(dtt_pkg::REQ_REMOVE, dtt_pkg::PT_WRITE, TOP_ADDR,
                             16'hFFFF, 8'hFF, 1'b1, 1'b1), RES_BAD_LEN});
    directed_rows.push_back({3'b001, mk_req(dtt_pkg::REQ_INSERT, PT_UNKNOWN, 64'h1000, 16'd0,
                             8'd0, 1'b0, 1'b1), RES_OK});
    directed_rows.push_back({3'b001, mk_req(dtt_pkg::REQ_REMOVE, PT_UNKNOWN, 64'h1000,
                             16'hFFFF, 8'd0, 1'b0, 1'b1), RES_OK});
    directed_rows.push_back({3'b001, mk_req(REQ_UNKNOWN, PT_UNKNOWN, TOP_ADDR, 16'hFFFF, 8'hFF,
                             1'b1, 1'b1), RES_OK});
    directed_rows.push_back({3'b001, mk_req(dtt_pkg::REQ_INSERT, dtt_pkg::PT_SW, 64'h1000,
                             16'd1, 8'd0, 1'b0, 1'b1), RES_OK});
    directed_rows.push_back({3'b001, mk_req(dtt_pkg::REQ_EXEC, dtt_pkg::PT_SW, 64'h1000,
                             16'd0, 8'd0, 1'b0, 1'b1), RES_OK});
    directed_rows.push_back({3'b110, mk_req(dtt_pkg::REQ_EXEC, dtt_pkg::PT_SW, 64'h1000,
                             16'd0, 8'd0, 1'b0, 1'b1), RES_UNTYPED});
    // duplicate insert, other length
    directed_rows.push_back({3'b000, mk_req(dtt_pkg::REQ_INSERT, dtt_pkg::PT_SW, 64'h1000,
                             16'd5, 8'd0, 1'b0, 1'b1), RES_UNTYPED});
    directed_rows.push_back({3'b000, mk_req(dtt_pkg::REQ_INSERT, dtt_pkg::PT_HW, TOP_ADDR,
                             16'd4096, 8'd0, 1'b0, 1'b1), RES_UNTYPED});
    directed_rows.push_back({3'b000, mk_req(dtt_pkg::REQ_EXEC, dtt_pkg::PT_SW, TOP_ADDR,
                             16'd0, 8'd0, 1'b0, 1'b1), RES_UNTYPED});
    // both range ends pinned at the top
    directed_rows.push_back({3'b000, mk_req(dtt_pkg::REQ_INSERT, dtt_pkg::PT_WRITE,
                             64'hFFFF_FFFF_FFFF_FFF0, 16'd4096, 8'd0, 1'b0, 1'b1),
                             RES_UNTYPED});
    directed_rows.push_back({3'b000, mk_req(dtt_pkg::REQ_DATA, dtt_pkg::PT_SW, TOP_ADDR,
                             16'd0, 8'hFF, 1'b1, 1'b1), RES_UNTYPED});
    directed_rows.push_back({3'b001, mk_req(dtt_pkg::REQ_DATA, dtt_pkg::PT_SW, TOP_ADDR,
                             16'd0, 8'hFF, 1'b1, 1'b0), RES_OK});
    directed_rows.push_back({3'b001, mk_req(dtt_pkg::REQ_DATA, dtt_pkg::PT_SW, TOP_ADDR,
                             16'd0, 8'd0, 1'b1, 1'b1), RES_OK});
    directed_rows.push_back({3'b000, mk_req(dtt_pkg::REQ_INSERT, dtt_pkg::PT_READ, '0,
                             16'd4096, 8'd0, 1'b0, 1'b1), RES_UNTYPED});
    directed_rows.push_back({3'b000, mk_req(dtt_pkg::REQ_DATA, dtt_pkg::PT_SW, 64'h0FFF,
                             16'd0, 8'd1, 1'b0, 1'b1), RES_UNTYPED});
    directed_rows.push_back({3'b000, mk_req(dtt_pkg::REQ_DATA, dtt_pkg::PT_SW, 64'h0FFF,
                             16'd0, 8'd1, 1'b1, 1'b1), RES_UNTYPED});
    directed_rows.push_back({3'b000, mk_req(dtt_pkg::REQ_INSERT, dtt_pkg::PT_ACCESS, 64'h2000,
                             16'd1, 8'd0, 1'b0, 1'b1), RES_UNTYPED});
    directed_rows.push_back({3'b000, mk_req(dtt_pkg::REQ_DATA, dtt_pkg::PT_SW, 64'h1FFF,
                             16'd0, 8'd2, 1'b1, 1'b1), RES_UNTYPED});
    directed_rows.push_back({3'b000, mk_req(dtt_pkg::REQ_REMOVE, dtt_pkg::PT_SW, 64'h1000,
                             16'd1, 8'd0, 1'b0, 1'b1), RES_UNTYPED});
    directed_rows.push_back({3'b001, mk_req(dtt_pkg::REQ_REMOVE, dtt_pkg::PT_SW, 64'h1000,
                             16'd1, 8'd0, 1'b0, 1'b1), RES_OK});
    directed_rows.push_back({3'b000, mk_req(dtt_pkg::REQ_EXEC, dtt_pkg::PT_SW, 64'h1000,
                             16'd0, 8'd0, 1'b0, 1'b1), RES_UNTYPED});
    directed_rows.push_back({3'b001, mk_req(dtt_pkg::REQ_CLEAR, dtt_pkg::PT_SW, '0, 16'd0,
                             8'd0, 1'b0, 1'b1), RES_OK});
    directed_rows.push_back({3'b000, mk_req(dtt_pkg::REQ_EXEC, dtt_pkg::PT_SW, TOP_ADDR,
                             16'd0, 8'd0, 1'b0, 1'b1), RES_UNTYPED});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.set_cfg) write_debug_enable(row.cfg_val);
      send_request(row.rq, row.typed, row.res);
      sender_gap();
    end

    // fill every slot, then one more insert for a full table
    for (int i = 0; i <= SLOTS; i++) begin
      send_request(mk_req(dtt_pkg::REQ_INSERT, kinds[i % 5], FILL_BASE + 64 * i,
                          (dtt_pkg::PLEN_W)'($urandom_range(64, 1)), 8'd0, 1'b0, 1'b1),
                   1'b0, RES_UNTYPED);
      sender_gap();
    end
    send_request(mk_req(dtt_pkg::REQ_EXEC, dtt_pkg::PT_SW, FILL_BASE + 64 * (SLOTS - 1),
                        16'd0, 8'd0, 1'b0, 1'b1), 1'b0, RES_UNTYPED);
    for (int i = 0; i < 8; i++) begin
      send_request(mk_req(dtt_pkg::REQ_DATA, dtt_pkg::PT_SW,
                          FILL_BASE + $urandom_range(SLOTS * 64 + 8, 0), 16'd0,
                          (dtt_pkg::ALEN_W)'($urandom_range(8, 1)),
                          1'($urandom_range(1, 0)), 1'b1),
                   1'b0, RES_UNTYPED);
      sender_gap();
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      steady = (ph == PHASES - 1);
      case ($urandom_range(2, 0))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 35;
      endcase
      case ($urandom_range(2, 0))
        0:       stall_pct = 0;
        1:       stall_pct = 10;
        default: stall_pct = 35;
      endcase
      if (ph == 0) write_debug_enable(1'b0);
      else if (ph == 1 || steady) write_debug_enable(1'b1);
      else write_debug_enable($urandom_range(3, 0) != 0);

      pool[0] = '0;
      pool[1] = TOP_ADDR;
      pool[2] = FILL_BASE + 64 * $urandom_range(SLOTS - 1, 0);
      pool[3] = {$urandom, $urandom};
      pool[4] = pool[3] + $urandom_range(MAX_LEN, 1);
      pool[5] = TOP_ADDR - $urandom_range(MAX_LEN - 1, 0);
      pool[6] = (dtt_pkg::ADDR_W)'($urandom_range(MAX_LEN - 1, 0));
      pool[7] = {$urandom, $urandom};

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99, 0);
        if (pick < 30) r.req_type = dtt_pkg::REQ_INSERT;
        else if (pick < 45) r.req_type = dtt_pkg::REQ_REMOVE;
        else if (pick < 47) r.req_type = dtt_pkg::REQ_CLEAR;
        else if (pick < 62) r.req_type = dtt_pkg::REQ_EXEC;
        else if (pick < 97) r.req_type = dtt_pkg::REQ_DATA;
        else r.req_type = (dtt_pkg::REQ_W)'($urandom_range(REQ_UNKNOWN, REQ_UNKNOWN_LO));

        if ($urandom_range(15, 0) == 0)
          r.point_type = (dtt_pkg::PT_W)'($urandom_range(PT_UNKNOWN, PT_UNKNOWN_LO));
        else
          r.point_type = (dtt_pkg::PT_W)'($urandom_range(dtt_pkg::PT_ACCESS, dtt_pkg::PT_SW));

        lr = $urandom_range(19, 0);
        case (lr)
          0:       r.point_len = '0;
          1:       r.point_len = (dtt_pkg::PLEN_W)'(MAX_LEN);
          2:       r.point_len = (dtt_pkg::PLEN_W)'($urandom_range(16'hFFFF, MAX_LEN + 1));
          3:       r.point_len = (dtt_pkg::PLEN_W)'($urandom);
          4, 5, 6: r.point_len = (dtt_pkg::PLEN_W)'($urandom_range(MAX_LEN, 1));
          default: r.point_len = (dtt_pkg::PLEN_W)'($urandom_range(64, 1));
        endcase

        base = pool[$urandom_range(7, 0)];
        off  = $urandom_range(64, 0);
        if (r.req_type == dtt_pkg::REQ_DATA) begin
          if ($urandom_range(9, 0) == 0) r.address = {$urandom, $urandom};
          else if ($urandom_range(1, 0) != 0) r.address = base + off;
          else r.address = base - off;
        end else if (r.req_type == dtt_pkg::REQ_EXEC && $urandom_range(7, 0) == 0) begin
          r.address = {$urandom, $urandom};
        end else begin
          r.address = base;
        end

        if ($urandom_range(4, 0) == 0)
          r.access_len = (dtt_pkg::ALEN_W)'($urandom_range(255, 0));
        else
          r.access_len = (dtt_pkg::ALEN_W)'($urandom_range(8, 0));
        r.store       = 1'($urandom_range(1, 0));
        r.cpu_running = $urandom_range(9, 0) != 0;

        send_request(r, 1'b0, RES_UNTYPED);
        sender_gap();
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (error_count == 0) begin
      $display("debug_trigger_table_tb: PASS");
    end else begin
      $display("debug_trigger_table_tb: FAIL");
    end
    $finish;
  end

endmodule
